@@ hw/rtl/asfr_pkg.sv @@
`default_nettype none

package asfr_pkg;

  localparam int MaxFrameDefault = 64;
  localparam int PayloadBytes    = 10;
  localparam int MinFrame        = 12;
  localparam int LenOffset       = 3;
  localparam int CurTempMinCount = 23;
  localparam int OutTempMinCount = 24;

  localparam logic [7:0]  PollHdrReset  = 8'h70;
  localparam logic [7:0]  CtrlHdrReset  = 8'hF0;
  localparam logic [15:0] GapReset      = 16'd20;
  localparam logic        OutsideReset  = 1'b0;
  localparam logic [7:0]  TempMissing   = 8'h80;
  localparam logic [7:0]  FanAutoCode   = 8'hA0;
  localparam int          NanoexBit     = 6;

  // Frame byte positions of the captured temperature bytes and of the payload start
  localparam int PosCurTemp  = 18;
  localparam int PosOutTemp  = 19;
  localparam int PosCurAlt   = 21;
  localparam int PosOutAlt   = 22;
  localparam int PosPayload  = 2;

  typedef enum logic [1:0] {
    RegPollHdr  = 2'd0,
    RegCtrlHdr  = 2'd1,
    RegGap      = 2'd2,
    RegOutside  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadHdr   = 3'd2,
    StLenErr   = 3'd3,
    StSumErr   = 3'd4,
    StControl  = 3'd5,
    StTooLong  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ClOff      = 3'd0,
    ClHeatCool = 3'd1,
    ClCool     = 3'd2,
    ClHeat     = 3'd3,
    ClDry      = 3'd4,
    ClFanOnly  = 3'd5
  } climate_e;

  typedef enum logic [2:0] {
    FanAuto    = 3'd0,
    FanL1      = 3'd1,
    FanL2      = 3'd2,
    FanL3      = 3'd3,
    FanL4      = 3'd4,
    FanL5      = 3'd5,
    FanUnknown = 3'd6
  } fan_e;

  typedef enum logic [3:0] {
    VsUnsupported = 4'd0,
    VsUp          = 4'd1,
    VsMidUp       = 4'd2,
    VsMid         = 4'd3,
    VsMidDown     = 4'd4,
    VsDown        = 4'd5,
    VsSwing       = 4'd6,
    VsAuto        = 4'd7,
    VsUnknown     = 4'd8
  } vswing_e;

  typedef enum logic [2:0] {
    HsUnsupported  = 3'd0,
    HsLeft         = 3'd1,
    HsCentreLeft   = 3'd2,
    HsCentre       = 3'd3,
    HsCentreRight  = 3'd4,
    HsRight        = 3'd5,
    HsAuto         = 3'd6,
    HsUnknown      = 3'd7
  } hswing_e;

  typedef enum logic [1:0] {
    PrNormal   = 2'd0,
    PrPowerful = 2'd1,
    PrQuiet    = 2'd2
  } preset_e;

  typedef struct packed {
    logic [7:0]  poll_hdr;
    logic [7:0]  ctrl_hdr;
    logic [15:0] gap_ticks;
    logic        outside_en;
  } cfg_t;

  typedef struct packed {
    logic                             overflow;
    logic [7:0]                       header;
    logic [7:0]                       length;
    logic [7:0]                       sum;
    logic [PayloadBytes-1:0][7:0]     payload;
    logic [3:0][7:0]                  temps;
  } frame_t;

  typedef struct packed {
    status_e            status;
    climate_e           climate;
    fan_e               fan;
    vswing_e            vswing;
    hswing_e            hswing;
    logic [1:0]         swing_sum;
    preset_e            preset;
    logic               nanoex;
    logic [7:0]         target_raw;
    logic signed [7:0]  cur_temp;
    logic signed [7:0]  out_temp;
    logic [1:0]         temp_valid;
  } result_t;

  function automatic climate_e mode_code(logic [7:0] v);
    climate_e c;
    c = ClOff;
    if (v[3:0] != 4'h0) begin
      unique case (v[7:4])
        4'h0: c = ClHeatCool;
        4'h3: c = ClCool;
        4'h4: c = ClHeat;
        4'h2: c = ClDry;
        4'h6: c = ClFanOnly;
        default: c = ClOff;
      endcase
    end
    return c;
  endfunction

  function automatic fan_e fan_code(logic [7:0] v);
    fan_e f;
    unique case (v)
      FanAutoCode: f = FanAuto;
      8'h30: f = FanL1;
      8'h40: f = FanL2;
      8'h50: f = FanL3;
      8'h60: f = FanL4;
      8'h70: f = FanL5;
      default: f = FanUnknown;
    endcase
    return f;
  endfunction

  function automatic vswing_e vert_code(logic [7:0] v);
    vswing_e s;
    unique case (v[7:4])
      4'h0: s = VsUnsupported;
      4'h1: s = VsUp;
      4'h2: s = VsMidUp;
      4'h3: s = VsMid;
      4'h4: s = VsMidDown;
      4'h5: s = VsDown;
      4'hE: s = VsSwing;
      4'hF: s = VsAuto;
      default: s = VsUnknown;
    endcase
    return s;
  endfunction

  function automatic hswing_e horiz_code(logic [7:0] v);
    hswing_e s;
    unique case (v[3:0])
      4'h0: s = HsUnsupported;
      4'h9: s = HsLeft;
      4'hA: s = HsCentreLeft;
      4'h6: s = HsCentre;
      4'hB: s = HsCentreRight;
      4'hC: s = HsRight;
      4'hD: s = HsAuto;
      default: s = HsUnknown;
    endcase
    return s;
  endfunction

  function automatic preset_e preset_code(logic [7:0] v);
    preset_e p;
    unique case (v[3:0])
      4'h2: p = PrPowerful;
      4'h4: p = PrQuiet;
      default: p = PrNormal;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/asfr_regs.sv @@
`default_nettype none

module asfr_regs (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output asfr_pkg::cfg_t           cfg_o
);

  asfr_pkg::cfg_t   cfg_q, cfg_d;
  asfr_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = asfr_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        asfr_pkg::RegPollHdr: cfg_d.poll_hdr   = pwdata[7:0];
        asfr_pkg::RegCtrlHdr: cfg_d.ctrl_hdr   = pwdata[7:0];
        asfr_pkg::RegGap:     cfg_d.gap_ticks  = pwdata[15:0];
        asfr_pkg::RegOutside: cfg_d.outside_en = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      asfr_pkg::RegPollHdr: prdata = {24'd0, cfg_q.poll_hdr};
      asfr_pkg::RegCtrlHdr: prdata = {24'd0, cfg_q.ctrl_hdr};
      asfr_pkg::RegGap:     prdata = {16'd0, cfg_q.gap_ticks};
      asfr_pkg::RegOutside: prdata = {31'd0, cfg_q.outside_en};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_hdr   <= asfr_pkg::PollHdrReset;
      cfg_q.ctrl_hdr   <= asfr_pkg::CtrlHdrReset;
      cfg_q.gap_ticks  <= asfr_pkg::GapReset;
      cfg_q.outside_en <= asfr_pkg::OutsideReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/asfr_frame.sv @@
`default_nettype none

module asfr_frame #(
  parameter int MAX_FRAME = asfr_pkg::MaxFrameDefault,
  localparam int CntW     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              out_free_i,
  input  wire logic [15:0]       gap_ticks_i,
  output logic                   end_o,
  output logic [CntW-1:0]        count_o,
  output asfr_pkg::frame_t       frame_o
);

  logic              in_vld_q, in_vld_d;
  logic              in_mode_q;
  logic [7:0]        in_byte_q;
  logic              accept, fire, take_byte, take_tick;

  logic [CntW-1:0]   count_q, count_d;
  logic [15:0]       idle_q, idle_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        sum_q, sum_d;
  logic              full;

  logic [7:0]                            header_q, length_q;
  logic [asfr_pkg::PayloadBytes-1:0][7:0] payload_q;
  logic [3:0][7:0]                       temps_q;

  assign in_stall_o = in_vld_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = in_vld_q && out_free_i;
  assign take_byte  = fire && !in_mode_q;
  assign take_tick  = fire && in_mode_q && ((count_q != '0) || ovf_q);
  assign end_o      = take_tick && (idle_q >= gap_ticks_i);
  assign full       = count_q >= CntW'(MAX_FRAME);

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    count_d = count_q;
    idle_d  = idle_q;
    ovf_d   = ovf_q;
    sum_d   = sum_q;
    if (take_byte) begin
      idle_d = '0;
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        sum_d   = sum_q + in_byte_q;
        count_d = count_q + CntW'(1);
      end
    end else if (end_o) begin
      count_d = '0;
      idle_d  = '0;
      ovf_d   = 1'b0;
      sum_d   = '0;
    end else if (take_tick) begin
      idle_d = idle_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      count_q  <= '0;
      idle_q   <= '0;
      ovf_q    <= 1'b0;
      sum_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      count_q  <= count_d;
      idle_q   <= idle_d;
      ovf_q    <= ovf_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_mode_q <= mode_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // Capture bytes at their fixed frame positions
  always_ff @(posedge clk_i) begin
    if (take_byte && !full) begin
      if (count_q == CntW'(0)) begin
        header_q <= in_byte_q;
      end
      if (count_q == CntW'(1)) begin
        length_q <= in_byte_q;
      end
      for (int k = 0; k < asfr_pkg::PayloadBytes; k++) begin
        if (count_q == CntW'(k + asfr_pkg::PosPayload)) begin
          payload_q[k] <= in_byte_q;
        end
      end
      if (count_q == CntW'(asfr_pkg::PosCurTemp)) begin
        temps_q[0] <= in_byte_q;
      end
      if (count_q == CntW'(asfr_pkg::PosOutTemp)) begin
        temps_q[1] <= in_byte_q;
      end
      if (count_q == CntW'(asfr_pkg::PosCurAlt)) begin
        temps_q[2] <= in_byte_q;
      end
      if (count_q == CntW'(asfr_pkg::PosOutAlt)) begin
        temps_q[3] <= in_byte_q;
      end
    end
  end

  assign count_o          = count_q;
  assign frame_o.overflow = ovf_q;
  assign frame_o.header   = header_q;
  assign frame_o.length   = length_q;
  assign frame_o.sum      = sum_q;
  assign frame_o.payload  = payload_q;
  assign frame_o.temps    = temps_q;

endmodule

`default_nettype wire

@@ hw/rtl/asfr_decode.sv @@
`default_nettype none

module asfr_decode #(
  parameter int MAX_FRAME = asfr_pkg::MaxFrameDefault,
  localparam int CntW     = $clog2(MAX_FRAME + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              end_i,
  input  wire logic [CntW-1:0]   count_i,
  input  wire asfr_pkg::frame_t  frame_i,
  input  wire asfr_pkg::cfg_t    cfg_i,
  input  wire logic              out_stall_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  output asfr_pkg::result_t      result_o
);

  logic                 vld_q, vld_d;
  asfr_pkg::result_t    res_q, res_d;
  asfr_pkg::status_e    status;
  logic [7:0]           cnt8, len_exp;
  logic                 is_poll, is_ctrl;

  assign cnt8    = 8'(count_i);
  assign len_exp = cnt8 - 8'(asfr_pkg::LenOffset);
  assign is_poll = frame_i.header == cfg_i.poll_hdr;
  assign is_ctrl = frame_i.header == cfg_i.ctrl_hdr;

  always_comb begin
    priority if (frame_i.overflow || (count_i > CntW'(MAX_FRAME))) begin
      status = asfr_pkg::StTooLong;
    end else if (count_i < CntW'(asfr_pkg::MinFrame)) begin
      status = asfr_pkg::StShort;
    end else if (!is_poll && !is_ctrl) begin
      status = asfr_pkg::StBadHdr;
    end else if (frame_i.length != len_exp) begin
      status = asfr_pkg::StLenErr;
    end else if (frame_i.sum != 8'd0) begin
      status = asfr_pkg::StSumErr;
    end else if (!is_poll) begin
      status = asfr_pkg::StControl;
    end else begin
      status = asfr_pkg::StOk;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = status;
    if (status == asfr_pkg::StOk) begin
      res_d.climate    = asfr_pkg::mode_code(frame_i.payload[0]);
      res_d.fan        = asfr_pkg::fan_code(frame_i.payload[3]);
      res_d.vswing     = asfr_pkg::vert_code(frame_i.payload[4]);
      res_d.hswing     = asfr_pkg::horiz_code(frame_i.payload[4]);
      res_d.swing_sum  = {res_d.hswing == asfr_pkg::HsAuto, res_d.vswing == asfr_pkg::VsAuto};
      res_d.preset     = asfr_pkg::preset_code(frame_i.payload[5]);
      res_d.nanoex     = frame_i.payload[5][asfr_pkg::NanoexBit];
      res_d.target_raw = frame_i.payload[1];
      if (count_i >= CntW'(asfr_pkg::CurTempMinCount)) begin
        if (frame_i.temps[0] != asfr_pkg::TempMissing) begin
          res_d.cur_temp      = frame_i.temps[0];
          res_d.temp_valid[0] = 1'b1;
        end else if (frame_i.temps[2] != asfr_pkg::TempMissing) begin
          res_d.cur_temp      = frame_i.temps[2];
          res_d.temp_valid[0] = 1'b1;
        end
      end
      if (cfg_i.outside_en && (count_i >= CntW'(asfr_pkg::OutTempMinCount))) begin
        if (frame_i.temps[1] != asfr_pkg::TempMissing) begin
          res_d.out_temp      = frame_i.temps[1];
          res_d.temp_valid[1] = 1'b1;
        end else if (frame_i.temps[3] != asfr_pkg::TempMissing) begin
          res_d.out_temp      = frame_i.temps[3];
          res_d.temp_valid[1] = 1'b1;
        end
      end
    end
  end

  assign out_free_o = !vld_q || !out_stall_i;
  assign vld_d      = end_i || (vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/ac_status_frame_receiver.sv @@
`default_nettype none

// Status frame receiver. Each item is either a received UART byte (mode 0) or a
// one-millisecond tick (mode 1). Bytes are gathered into a frame; when bytes are
// buffered and a tick arrives after at least gap_ticks idle ticks, the frame is
// checked and one result item gives its status and, for a good poll frame, the
// decoded payload and temperatures. An item is taken every cycle unless input is
// stalled: it passes an input register and then one processing stage into the
// result register, and input is stalled only while the result register holds an
// item that is itself stalled. Registers at byte addresses 0x0 poll header, 0x4
// control header, 0x8 gap ticks, 0xC outside sensor enable; write them only while
// the block is idle.
module ac_status_frame_receiver #(
  parameter int MAX_FRAME = asfr_pkg::MaxFrameDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic         mode_i,
  input  wire logic [7:0]   rx_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [2:0]        frame_status_o,
  output logic [2:0]        climate_mode_o,
  output logic [2:0]        fan_speed_o,
  output logic [3:0]        vertical_swing_o,
  output logic [2:0]        horizontal_swing_o,
  output logic [1:0]        swing_summary_o,
  output logic [1:0]        preset_o,
  output logic              nanoex_on_o,
  output logic [7:0]        target_temp_raw_o,
  output logic signed [7:0] current_temp_o,
  output logic signed [7:0] outside_temp_o,
  output logic [1:0]        temp_valid_o
);

  localparam int CntW = $clog2(MAX_FRAME + 1);

  asfr_pkg::cfg_t     cfg;
  asfr_pkg::frame_t   frame;
  asfr_pkg::result_t  result;
  logic [CntW-1:0]    count;
  logic               frame_end;
  logic               out_free;

  asfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  asfr_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .out_free_i  (out_free),
    .gap_ticks_i (cfg.gap_ticks),
    .end_o       (frame_end),
    .count_o     (count),
    .frame_o     (frame)
  );

  asfr_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .end_i       (frame_end),
    .count_i     (count),
    .frame_i     (frame),
    .cfg_i       (cfg),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign frame_status_o     = result.status;
  assign climate_mode_o     = result.climate;
  assign fan_speed_o        = result.fan;
  assign vertical_swing_o   = result.vswing;
  assign horizontal_swing_o = result.hswing;
  assign swing_summary_o    = result.swing_sum;
  assign preset_o           = result.preset;
  assign nanoex_on_o        = result.nanoex;
  assign target_temp_raw_o  = result.target_raw;
  assign current_temp_o     = result.cur_temp;
  assign outside_temp_o     = result.out_temp;
  assign temp_valid_o       = result.temp_valid;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register can move");

  a_bad_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_status_o != asfr_pkg::StOk)) |->
      ((temp_valid_o == 2'd0) && (climate_mode_o == asfr_pkg::ClOff) &&
       (target_temp_raw_o == 8'd0)))
    else $error("decoded fields set on a rejected frame");

  a_outside_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && temp_valid_o[1]) |-> cfg.outside_en)
    else $error("outside temperature reported with sensor disabled");

  a_end_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> out_valid_o)
    else $error("ended frame produced no result");

endmodule

`default_nettype wire

@@ dv/ac_status_frame_receiver_test.sv @@
module ac_status_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxFrame = asfr_pkg::MaxFrameDefault;

  typedef enum logic [2:0] {
    FrOk, FrControl, FrBadHeader, FrLength, FrChecksum, FrShort, FrLong
  } frame_kind_e;

  class frame_scoreboard;
    logic [7:0]  poll_hdr   = asfr_pkg::PollHdrReset;
    logic [7:0]  ctrl_hdr   = asfr_pkg::CtrlHdrReset;
    logic [15:0] gap        = asfr_pkg::GapReset;
    logic        outside_en = asfr_pkg::OutsideReset;

    int unsigned nbytes = 0;
    int unsigned idle = 0;
    bit          overflow = 0;
    logic [7:0]  byte_sum = '0;
    logic [7:0]  hdr, len;
    logic [7:0]  payload [asfr_pkg::PayloadBytes];
    logic [7:0]  temps [4];

    asfr_pkg::result_t pending_frames [$];
    int unsigned failures = 0;

    function string describe(asfr_pkg::result_t r);
      return $sformatf({"st=%0d cl=%0d fan=%0d vs=%0d hs=%0d sw=%0d pr=%0d nx=%0d",
                        " tgt=%0d cur=%0d out=%0d tv=%0d"},
                       r.status, r.climate, r.fan, r.vswing, r.hswing, r.swing_sum,
                       r.preset, r.nanoex, r.target_raw, r.cur_temp, r.out_temp,
                       r.temp_valid);
    endfunction

    function asfr_pkg::result_t judge_frame();
      asfr_pkg::result_t r;
      logic [7:0] sw;
      r = '0;
      if (overflow || nbytes > MaxFrame) r.status = asfr_pkg::StTooLong;
      else if (nbytes < asfr_pkg::MinFrame) r.status = asfr_pkg::StShort;
      else if (hdr != poll_hdr && hdr != ctrl_hdr) r.status = asfr_pkg::StBadHdr;
      else if (len != 8'(nbytes - asfr_pkg::LenOffset)) r.status = asfr_pkg::StLenErr;
      else if (byte_sum != 8'h00) r.status = asfr_pkg::StSumErr;
      else if (hdr != poll_hdr) r.status = asfr_pkg::StControl;
      else begin
        r.status = asfr_pkg::StOk;
        r.climate = asfr_pkg::ClOff;
        if (payload[0][3:0] != 4'h0) begin
          case (payload[0][7:4])
            4'h0: r.climate = asfr_pkg::ClHeatCool;
            4'h3: r.climate = asfr_pkg::ClCool;
            4'h4: r.climate = asfr_pkg::ClHeat;
            4'h2: r.climate = asfr_pkg::ClDry;
            4'h6: r.climate = asfr_pkg::ClFanOnly;
            default: r.climate = asfr_pkg::ClOff;
          endcase
        end
        case (payload[3])
          asfr_pkg::FanAutoCode: r.fan = asfr_pkg::FanAuto;
          8'h30: r.fan = asfr_pkg::FanL1;
          8'h40: r.fan = asfr_pkg::FanL2;
          8'h50: r.fan = asfr_pkg::FanL3;
          8'h60: r.fan = asfr_pkg::FanL4;
          8'h70: r.fan = asfr_pkg::FanL5;
          default: r.fan = asfr_pkg::FanUnknown;
        endcase
        sw = payload[4];
        if (sw[7:4] <= 4'd5) r.vswing = asfr_pkg::vswing_e'(sw[7:4]);
        else if (sw[7:4] == 4'hE) r.vswing = asfr_pkg::VsSwing;
        else if (sw[7:4] == 4'hF) r.vswing = asfr_pkg::VsAuto;
        else r.vswing = asfr_pkg::VsUnknown;
        case (sw[3:0])
          4'h0: r.hswing = asfr_pkg::HsUnsupported;
          4'h9: r.hswing = asfr_pkg::HsLeft;
          4'hA: r.hswing = asfr_pkg::HsCentreLeft;
          4'h6: r.hswing = asfr_pkg::HsCentre;
          4'hB: r.hswing = asfr_pkg::HsCentreRight;
          4'hC: r.hswing = asfr_pkg::HsRight;
          4'hD: r.hswing = asfr_pkg::HsAuto;
          default: r.hswing = asfr_pkg::HsUnknown;
        endcase
        r.swing_sum = {r.hswing == asfr_pkg::HsAuto, r.vswing == asfr_pkg::VsAuto};
        case (payload[5][3:0])
          4'h2: r.preset = asfr_pkg::PrPowerful;
          4'h4: r.preset = asfr_pkg::PrQuiet;
          default: r.preset = asfr_pkg::PrNormal;
        endcase
        r.nanoex = payload[5][asfr_pkg::NanoexBit];
        r.target_raw = payload[1];
        if (nbytes >= asfr_pkg::CurTempMinCount) begin
          if (temps[0] != asfr_pkg::TempMissing) begin
            r.cur_temp = temps[0];
            r.temp_valid[0] = 1'b1;
          end else if (temps[2] != asfr_pkg::TempMissing) begin
            r.cur_temp = temps[2];
            r.temp_valid[0] = 1'b1;
          end
        end
        if (outside_en && nbytes >= asfr_pkg::OutTempMinCount) begin
          if (temps[1] != asfr_pkg::TempMissing) begin
            r.out_temp = temps[1];
            r.temp_valid[1] = 1'b1;
          end else if (temps[3] != asfr_pkg::TempMissing) begin
            r.out_temp = temps[3];
            r.temp_valid[1] = 1'b1;
          end
        end
      end
      return r;
    endfunction

    function void take_item(logic is_tick, logic [7:0] b);
      if (!is_tick) begin
        idle = 0;
        if (nbytes >= MaxFrame) begin
          overflow = 1;
        end else begin
          byte_sum = byte_sum + b;
          case (nbytes)
            0: hdr = b;
            1: len = b;
            asfr_pkg::PosCurTemp: temps[0] = b;
            asfr_pkg::PosOutTemp: temps[1] = b;
            asfr_pkg::PosCurAlt: temps[2] = b;
            asfr_pkg::PosOutAlt: temps[3] = b;
            default:
              if (nbytes < asfr_pkg::PosPayload + asfr_pkg::PayloadBytes)
                payload[nbytes - asfr_pkg::PosPayload] = b;
          endcase
          nbytes++;
        end
      end else if (nbytes != 0 || overflow) begin
        if (idle >= gap) begin
          pending_frames = {pending_frames, judge_frame()};
          nbytes = 0;
          overflow = 0;
          byte_sum = '0;
          idle = 0;
        end else begin
          idle++;
        end
      end
    endfunction

    function void check_frame(asfr_pkg::result_t got);
      asfr_pkg::result_t want;
      if (pending_frames.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = pending_frames.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: want %s", describe(want));
          $display("          got  %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid_i = 1'b0;
  wire         in_stall_o;
  logic        mode_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  wire         out_valid_o;
  logic        out_stall_i = 1'b0;
  wire  [2:0]  frame_status_o;
  wire  [2:0]  climate_mode_o;
  wire  [2:0]  fan_speed_o;
  wire  [3:0]  vertical_swing_o;
  wire  [2:0]  horizontal_swing_o;
  wire  [1:0]  swing_summary_o;
  wire  [1:0]  preset_o;
  wire         nanoex_on_o;
  wire  [7:0]  target_temp_raw_o;
  wire  signed [7:0] current_temp_o;
  wire  signed [7:0] outside_temp_o;
  wire  [1:0]  temp_valid_o;

  frame_scoreboard   sb;
  logic [7:0]        frame_bytes [$];
  asfr_pkg::result_t seen_result;
  int unsigned       counted = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       stall_left = 0;
  bit                calm = 0;

  ac_status_frame_receiver u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_status_o     (frame_status_o),
    .climate_mode_o     (climate_mode_o),
    .fan_speed_o        (fan_speed_o),
    .vertical_swing_o   (vertical_swing_o),
    .horizontal_swing_o (horizontal_swing_o),
    .swing_summary_o    (swing_summary_o),
    .preset_o           (preset_o),
    .nanoex_on_o        (nanoex_on_o),
    .target_temp_raw_o  (target_temp_raw_o),
    .current_temp_o     (current_temp_o),
    .outside_temp_o     (outside_temp_o),
    .temp_valid_o       (temp_valid_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_item(mode_i, rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        seen_result.status     = asfr_pkg::status_e'(frame_status_o);
        seen_result.climate    = asfr_pkg::climate_e'(climate_mode_o);
        seen_result.fan        = asfr_pkg::fan_e'(fan_speed_o);
        seen_result.vswing     = asfr_pkg::vswing_e'(vertical_swing_o);
        seen_result.hswing     = asfr_pkg::hswing_e'(horizontal_swing_o);
        seen_result.swing_sum  = swing_summary_o;
        seen_result.preset     = asfr_pkg::preset_e'(preset_o);
        seen_result.nanoex     = nanoex_on_o;
        seen_result.target_raw = target_temp_raw_o;
        seen_result.cur_temp   = current_temp_o;
        seen_result.out_temp   = outside_temp_o;
        seen_result.temp_valid = temp_valid_o;
        sb.check_frame(seen_result);
      end
    end
  end

  // hold the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(1, 15) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(logic is_tick, logic [7:0] b);
    in_valid_i <= 1'b1;
    mode_i <= is_tick;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    counted++;
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic reg_write(asfr_pkg::reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] poll, logic [7:0] ctrl, logic [15:0] gap,
                            logic outside_en);
    reg_write(asfr_pkg::RegPollHdr, {24'h0, poll});
    reg_write(asfr_pkg::RegCtrlHdr, {24'h0, ctrl});
    reg_write(asfr_pkg::RegGap, {16'h0, gap});
    reg_write(asfr_pkg::RegOutside, {31'h0, outside_en});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.poll_hdr = poll;
    sb.ctrl_hdr = ctrl;
    sb.gap = gap;
    sb.outside_en = outside_en;
  endtask

  // drop valid, wait for every result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic void build_frame(frame_kind_e kind, int n);
    int span;
    logic [7:0] b, total, delta;
    span = (kind == FrShort) ? asfr_pkg::MinFrame : n;
    b = (kind == FrControl) ? sb.ctrl_hdr : sb.poll_hdr;
    if (kind == FrBadHeader) begin
      do b = 8'($urandom); while (b == sb.poll_hdr || b == sb.ctrl_hdr);
    end
    frame_bytes.delete();
    frame_bytes = {frame_bytes, b};
    frame_bytes = {frame_bytes, 8'(span - asfr_pkg::LenOffset)};
    for (int i = 2; i < span - 1; i++) begin
      b = 8'($urandom);
      case (i)
        2: begin
          if ($urandom_range(1)) b[7:4] = 4'($urandom_range(6));
          if ($urandom_range(5) == 0) b[3:0] = 4'h0;
        end
        5: if ($urandom_range(1))
             b = ($urandom_range(5) == 0) ? asfr_pkg::FanAutoCode
                                          : {4'($urandom_range(3, 7)), 4'h0};
        6: begin
          if ($urandom_range(1)) b[7:4] = $urandom_range(1) ? 4'hF : 4'hE;
          if ($urandom_range(1)) b[3:0] = 4'($urandom_range(9, 13));
        end
        7: if ($urandom_range(1)) b[3:0] = $urandom_range(1) ? 4'h2 : 4'h4;
        asfr_pkg::PosCurTemp, asfr_pkg::PosOutTemp, asfr_pkg::PosCurAlt,
        asfr_pkg::PosOutAlt:
          if ($urandom_range(2) == 0) b = asfr_pkg::TempMissing;
        default: ;
      endcase
      frame_bytes = {frame_bytes, b};
    end
    total = '0;
    foreach (frame_bytes[i]) total = total + frame_bytes[i];
    frame_bytes = {frame_bytes, 8'h00 - total};
    delta = 8'($urandom_range(1, 255));
    if (kind == FrLength) begin
      frame_bytes[1] = frame_bytes[1] + delta;
      frame_bytes[span - 1] = frame_bytes[span - 1] - delta;
    end
    if (kind == FrChecksum) frame_bytes[span - 1] = frame_bytes[span - 1] + delta;
    if (kind == FrShort) while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endfunction

  // overwrite one byte and keep the sum at zero through the last byte
  function automatic void set_byte(int pos, logic [7:0] value);
    int last;
    last = frame_bytes.size() - 1;
    frame_bytes[last] = frame_bytes[last] - (value - frame_bytes[pos]);
    frame_bytes[pos] = value;
  endfunction

  task automatic send_frame();
    int unsigned quiet;
    quiet = (sb.gap > 8) ? 8 : sb.gap;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom));
    foreach (frame_bytes[i]) begin
      send_item(1'b0, frame_bytes[i]);
      if (quiet != 0 && $urandom_range(7) == 0)
        repeat ($urandom_range(1, quiet)) send_item(1'b1, 8'($urandom));
    end
    repeat (int'(sb.gap) + 1) send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(10, 40)) begin
      if ($urandom_range(1)) begin
        send_item(1'b0, 8'($urandom));
      end else begin
        send_item(1'b1, 8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned pick, phase;
    logic [7:0] poll_v, ctrl_v;
    sb = new;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    stall_pct = 10;
    repeat (3) send_item(1'b1, 8'hFF);
    build_frame(FrOk, 24);
    send_frame();
    settle();

    set_config(8'h70, 8'hF0, 16'd1, 1'b1);
    build_frame(FrOk, asfr_pkg::MinFrame);
    set_byte(2, 8'h00);
    set_byte(3, 8'hFF);
    send_frame();
    build_frame(FrOk, 23);
    set_byte(3, 8'h00);
    send_frame();
    build_frame(FrOk, 24);
    set_byte(asfr_pkg::PosCurTemp, 8'h7F);
    set_byte(asfr_pkg::PosOutTemp, 8'h81);
    send_frame();
    build_frame(FrOk, 24);
    set_byte(asfr_pkg::PosCurTemp, asfr_pkg::TempMissing);
    set_byte(asfr_pkg::PosOutTemp, asfr_pkg::TempMissing);
    set_byte(asfr_pkg::PosCurAlt, 8'h00);
    set_byte(asfr_pkg::PosOutAlt, 8'hFF);
    send_frame();
    build_frame(FrOk, 24);
    set_byte(asfr_pkg::PosCurTemp, asfr_pkg::TempMissing);
    set_byte(asfr_pkg::PosOutTemp, asfr_pkg::TempMissing);
    set_byte(asfr_pkg::PosCurAlt, asfr_pkg::TempMissing);
    set_byte(asfr_pkg::PosOutAlt, asfr_pkg::TempMissing);
    send_frame();
    build_frame(FrOk, MaxFrame);
    send_frame();
    build_frame(FrControl, asfr_pkg::MinFrame);
    send_frame();
    build_frame(FrBadHeader, 16);
    send_frame();
    build_frame(FrLength, 20);
    send_frame();
    build_frame(FrChecksum, 20);
    send_frame();
    build_frame(FrShort, 1);
    send_frame();
    build_frame(FrShort, asfr_pkg::MinFrame - 1);
    send_frame();
    build_frame(FrLong, MaxFrame + 1);
    send_frame();
    settle();

    // equal headers decode as poll; a zero gap ends on the first tick
    set_config(8'h5A, 8'h5A, 16'd0, 1'b0);
    build_frame(FrControl, 24);
    send_frame();
    build_frame(FrOk, asfr_pkg::MinFrame);
    send_frame();
    settle();

    set_config(8'h00, 8'hFF, 16'd300, 1'b1);
    build_frame(FrOk, 24);
    send_frame();
    settle();

    phase = 0;
    while (counted < 1700) begin
      calm = (counted > 1450);
      idle_pct = $urandom_range(2) * 15;
      stall_pct = $urandom_range(2) * 10;
      poll_v = 8'($urandom);
      ctrl_v = ($urandom_range(7) == 0) ? poll_v : 8'($urandom);
      if (phase == 0) begin
        poll_v = 8'hFF;
        ctrl_v = 8'h00;
      end else if (phase == 1) begin
        poll_v = 8'h00;
        ctrl_v = 8'hFF;
      end
      set_config(poll_v, ctrl_v, 16'($urandom_range(1, 6)), 1'($urandom));
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(99);
        if (pick < 60)
          build_frame(FrOk, ($urandom_range(3) == 0)
                              ? $urandom_range(asfr_pkg::MinFrame, MaxFrame)
                              : $urandom_range(asfr_pkg::MinFrame, 26));
        else if (pick < 65) build_frame(FrControl, $urandom_range(asfr_pkg::MinFrame, 30));
        else if (pick < 70) build_frame(FrBadHeader, $urandom_range(asfr_pkg::MinFrame, 30));
        else if (pick < 75) build_frame(FrLength, $urandom_range(asfr_pkg::MinFrame, 30));
        else if (pick < 80) build_frame(FrChecksum, $urandom_range(asfr_pkg::MinFrame, 30));
        else if (pick < 85) build_frame(FrShort, $urandom_range(1, asfr_pkg::MinFrame - 1));
        else if (pick < 90) build_frame(FrLong, $urandom_range(MaxFrame + 1, MaxFrame + 8));
        if (pick >= 90) send_noise();
        else send_frame();
      end
      repeat (int'(sb.gap) + 1) send_item(1'b1, 8'($urandom));
      settle();
      phase++;
    end

    if (sb.failures == 0 && sb.pending_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
